[src/qvnsm_pkg.sv]
// shared types and constants of the quad view nearest scaler map
package qvnsm_pkg;

    localparam int CANVAS_WIDTH_DEF   = 1280;
    localparam int CANVAS_HEIGHT_DEF  = 960;
    localparam int MAX_SOURCE_DIM_DEF = 2048;

    localparam int NUM_CH      = 4;
    localparam int CH_W        = 2;
    localparam int DIM_W       = 12;
    localparam int CANVAS_XW   = 11;
    localparam int CANVAS_YW   = 10;
    localparam int SRC_COORD_W = 11;
    localparam int OFFS_W      = 24;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // one canvas pixel asked about
    typedef struct packed {
        logic [CANVAS_XW-1:0] canvas_x;
        logic [CANVAS_YW-1:0] canvas_y;
    } t_in;

    // mapping result of one pixel
    typedef struct packed {
        logic                   covered;
        logic [CH_W-1:0]        channel;
        logic [SRC_COORD_W-1:0] src_x;
        logic [SRC_COORD_W-1:0] src_y;
        logic [OFFS_W-1:0]      src_byte_offset;
    } t_out;

    // control that travels with each pixel down the pipeline
    typedef struct packed {
        logic            valid;
        logic            cov;
        logic [CH_W-1:0] ch;
        logic            sel_h;
    } t_ctrl;

    typedef enum logic [1:0] {
        G_IDLE,
        G_CMP,
        G_DIV,
        G_STORE
    } t_gstate;

endpackage

[src/qvnsm_geom.sv]
// per-channel letterbox geometry solver with a bit-serial divider
module qvnsm_geom #(
    parameter int CELL_W = 640,
    parameter int CELL_H = 480,
    parameter int QW     = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [qvnsm_pkg::CH_W-1:0]    i_wr_ch,
    input  logic [qvnsm_pkg::DIM_W-1:0]   i_src_w [qvnsm_pkg::NUM_CH],
    input  logic [qvnsm_pkg::DIM_W-1:0]   i_src_h [qvnsm_pkg::NUM_CH],
    input  logic [qvnsm_pkg::CH_W-1:0]    i_rd_ch,
    output logic                          o_rd_sel_h,
    output logic [QW-1:0]                 o_rd_dw,
    output logic [QW-1:0]                 o_rd_dh,
    output logic [QW-1:0]                 o_rd_ox,
    output logic [QW-1:0]                 o_rd_oy,
    output logic                          o_busy
);
    import qvnsm_pkg::*;

    localparam int PW  = DIM_W + QW;
    localparam int CNW = $clog2(QW);

    t_gstate r_state, n_state;
    logic [NUM_CH-1:0] r_dirty, n_dirty;
    logic [CH_W-1:0]   pick;
    logic [CH_W-1:0]   r_ch;
    logic [DIM_W-1:0]  r_w, r_h;
    logic [PW-1:0]     r_pw, r_ph;
    logic              r_sel_h;
    logic [PW-1:0]     r_rem, r_dsh;
    logic [QW-1:0]     r_q;
    logic [CNW-1:0]    r_cnt;
    logic [QW-1:0]     st_dw, st_dh;

    logic              r_sel_tab [NUM_CH];
    logic [QW-1:0]     r_dw [NUM_CH];
    logic [QW-1:0]     r_dh [NUM_CH];
    logic [QW-1:0]     r_ox [NUM_CH];
    logic [QW-1:0]     r_oy [NUM_CH];

    // lowest pending channel first
    always_comb begin
        if (r_dirty[0]) begin
            pick = 2'd0;
        end else if (r_dirty[1]) begin
            pick = 2'd1;
        end else if (r_dirty[2]) begin
            pick = 2'd2;
        end else begin
            pick = 2'd3;
        end
    end

    always_comb begin
        n_state = r_state;
        n_dirty = r_dirty;
        case (r_state)
            G_IDLE: begin
                if (|r_dirty) begin
                    n_state       = G_CMP;
                    n_dirty[pick] = 1'b0;
                end
            end
            G_CMP:   n_state = G_DIV;
            G_DIV: begin
                if (r_cnt == '0) n_state = G_STORE;
            end
            G_STORE: n_state = G_IDLE;
            default: n_state = G_IDLE;
        endcase
        if (i_wr) n_dirty[i_wr_ch] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_dirty <= '0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
        end
    end

    // fitted size: the side of the limiting axis fills the cell
    assign st_dw = r_sel_h ? r_q : QW'(CELL_W);
    assign st_dh = r_sel_h ? QW'(CELL_H) : r_q;

    always_ff @(posedge i_clk) begin
        case (r_state)
            G_IDLE: begin
                r_ch <= pick;
                r_w  <= i_src_w[pick];
                r_h  <= i_src_h[pick];
                r_pw <= PW'(CELL_H) * PW'(i_src_w[pick]);
                r_ph <= PW'(CELL_W) * PW'(i_src_h[pick]);
            end
            G_CMP: begin
                // height limits when cell_w*h > cell_h*w
                r_sel_h <= (r_ph > r_pw);
                r_rem   <= (r_ph > r_pw) ? r_pw : r_ph;
                r_dsh   <= ((r_ph > r_pw) ? PW'(r_h) : PW'(r_w)) << (QW - 1);
                r_q     <= '0;
                r_cnt   <= CNW'(QW - 1);
            end
            G_DIV: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            G_STORE: begin
                r_sel_tab[r_ch] <= r_sel_h;
                r_dw[r_ch]      <= st_dw;
                r_dh[r_ch]      <= st_dh;
                r_ox[r_ch]      <= (QW'(CELL_W) - st_dw) >> 1;
                r_oy[r_ch]      <= (QW'(CELL_H) - st_dh) >> 1;
            end
            default: begin
            end
        endcase
    end

    assign o_rd_sel_h = r_sel_tab[i_rd_ch];
    assign o_rd_dw    = r_dw[i_rd_ch];
    assign o_rd_dh    = r_dh[i_rd_ch];
    assign o_rd_ox    = r_ox[i_rd_ch];
    assign o_rd_oy    = r_oy[i_rd_ch];
    assign o_busy     = (|r_dirty) || (r_state != G_IDLE);

endmodule

[src/qvnsm_front.sv]
// quadrant select, coverage test and scaled dividends
module qvnsm_front #(
    parameter int CELL_W         = 640,
    parameter int CELL_H         = 480,
    parameter int MAX_SOURCE_DIM = 2048,
    parameter int QW             = 10,
    parameter int RW             = 23
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  qvnsm_pkg::t_in                i_pixel,
    input  logic [qvnsm_pkg::DIM_W-1:0]   i_src_w [qvnsm_pkg::NUM_CH],
    input  logic [qvnsm_pkg::DIM_W-1:0]   i_src_h [qvnsm_pkg::NUM_CH],
    output logic [qvnsm_pkg::CH_W-1:0]    o_rd_ch,
    input  logic                          i_rd_sel_h,
    input  logic [QW-1:0]                 i_rd_dw,
    input  logic [QW-1:0]                 i_rd_dh,
    input  logic [QW-1:0]                 i_rd_ox,
    input  logic [QW-1:0]                 i_rd_oy,
    output qvnsm_pkg::t_ctrl              o_ctrl,
    output logic [qvnsm_pkg::DIM_W-1:0]   o_w,
    output logic [RW-1:0]                 o_rem_x,
    output logic [RW-1:0]                 o_rem_y
);
    import qvnsm_pkg::*;

    localparam int EW = (QW + 1 > CANVAS_XW) ? QW + 1 : CANVAS_XW;
    localparam int MW = DIM_W + 1;

    logic [EW-1:0]    xe, ye, cx, cy, lxe, lye;
    logic             col, row, on_canvas, present, in_x, in_y;
    logic [CH_W-1:0]  ch;
    logic [DIM_W-1:0] w, h;
    t_ctrl            n_s1_ctrl, r_s1_ctrl, r_s2_ctrl;
    logic [QW-1:0]    r_s1_lx, r_s1_ly;
    logic [DIM_W-1:0] r_s1_den, r_s1_w, r_s2_w;
    logic [RW-1:0]    r_s2_rem_x, r_s2_rem_y;

    always_comb begin
        xe        = EW'(i_pixel.canvas_x);
        ye        = EW'(i_pixel.canvas_y);
        col       = (xe >= EW'(CELL_W));
        row       = (ye >= EW'(CELL_H));
        on_canvas = (xe < EW'(2 * CELL_W)) && (ye < EW'(2 * CELL_H));
        ch        = {row, col};
        w         = i_src_w[ch];
        h         = i_src_h[ch];
        present   = (w != '0) && (h != '0) &&
                    (MW'(w) <= MW'(MAX_SOURCE_DIM)) && (MW'(h) <= MW'(MAX_SOURCE_DIM));
        cx        = xe - (col ? EW'(CELL_W) : '0);
        cy        = ye - (row ? EW'(CELL_H) : '0);
        lxe       = cx - EW'(i_rd_ox);
        lye       = cy - EW'(i_rd_oy);
        in_x      = (cx >= EW'(i_rd_ox)) && (lxe < EW'(i_rd_dw));
        in_y      = (cy >= EW'(i_rd_oy)) && (lye < EW'(i_rd_dh));

        n_s1_ctrl.valid = i_valid;
        n_s1_ctrl.cov   = on_canvas && present && in_x && in_y;
        n_s1_ctrl.ch    = ch;
        n_s1_ctrl.sel_h = i_rd_sel_h;
    end

    assign o_rd_ch = ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl <= '0;
            r_s2_ctrl <= '0;
        end else begin
            r_s1_ctrl <= n_s1_ctrl;
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    // local offset times the denominator, later divided by the cell size
    always_ff @(posedge i_clk) begin
        r_s1_lx    <= QW'(lxe);
        r_s1_ly    <= QW'(lye);
        r_s1_den   <= i_rd_sel_h ? h : w;
        r_s1_w     <= w;
        r_s2_rem_x <= RW'(r_s1_lx) * RW'(r_s1_den);
        r_s2_rem_y <= RW'(r_s1_ly) * RW'(r_s1_den);
        r_s2_w     <= r_s1_w;
    end

    assign o_ctrl  = r_s2_ctrl;
    assign o_w     = r_s2_w;
    assign o_rem_x = r_s2_rem_x;
    assign o_rem_y = r_s2_rem_y;

endmodule

[src/qvnsm_cell.sv]
// one quotient bit of the source x and y division by the cell size
module qvnsm_cell #(
    parameter int CELL_W = 640,
    parameter int CELL_H = 480,
    parameter int RW     = 23,
    parameter int SW     = 11,
    parameter int BIT    = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qvnsm_pkg::t_ctrl              i_ctrl,
    input  logic [qvnsm_pkg::DIM_W-1:0]   i_w,
    input  logic [RW-1:0]                 i_rem_x,
    input  logic [RW-1:0]                 i_rem_y,
    input  logic [SW-1:0]                 i_qx,
    input  logic [SW-1:0]                 i_qy,
    output qvnsm_pkg::t_ctrl              o_ctrl,
    output logic [qvnsm_pkg::DIM_W-1:0]   o_w,
    output logic [RW-1:0]                 o_rem_x,
    output logic [RW-1:0]                 o_rem_y,
    output logic [SW-1:0]                 o_qx,
    output logic [SW-1:0]                 o_qy
);
    import qvnsm_pkg::*;

    logic [RW-1:0]    dsh, n_rem_x, n_rem_y;
    logic [SW-1:0]    n_qx, n_qy;
    logic             ge_x, ge_y;
    t_ctrl            r_ctrl;
    logic [DIM_W-1:0] r_w;
    logic [RW-1:0]    r_rem_x, r_rem_y;
    logic [SW-1:0]    r_qx, r_qy;

    always_comb begin
        dsh       = (i_ctrl.sel_h ? RW'(CELL_H) : RW'(CELL_W)) << BIT;
        ge_x      = (i_rem_x >= dsh);
        ge_y      = (i_rem_y >= dsh);
        n_rem_x   = ge_x ? i_rem_x - dsh : i_rem_x;
        n_rem_y   = ge_y ? i_rem_y - dsh : i_rem_y;
        n_qx      = i_qx;
        n_qy      = i_qy;
        n_qx[BIT] = ge_x;
        n_qy[BIT] = ge_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= i_w;
        r_rem_x <= n_rem_x;
        r_rem_y <= n_rem_y;
        r_qx    <= n_qx;
        r_qy    <= n_qy;
    end

    assign o_ctrl  = r_ctrl;
    assign o_w     = r_w;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;

endmodule

[src/qvnsm_addr.sv]
// rgb888 byte offset and result register
module qvnsm_addr #(
    parameter int SW = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qvnsm_pkg::t_ctrl              i_ctrl,
    input  logic [qvnsm_pkg::DIM_W-1:0]   i_w,
    input  logic [SW-1:0]                 i_qx,
    input  logic [SW-1:0]                 i_qy,
    output logic                          o_done,
    output qvnsm_pkg::t_out               o_result
);
    import qvnsm_pkg::*;

    localparam int PRW = SW + DIM_W;
    localparam int OW  = PRW + 3;

    t_ctrl          r_ctrl;
    logic [PRW-1:0] r_prod;
    logic [SW-1:0]  r_qx, r_qy;
    logic [OW-1:0]  sum, off3;
    logic           r_done;
    t_out           n_result, r_result;

    always_comb begin
        sum  = OW'(r_prod) + OW'(r_qx);
        off3 = (sum << 1) + sum;
        n_result.covered         = r_ctrl.cov;
        n_result.channel         = r_ctrl.ch;
        n_result.src_x           = r_ctrl.cov ? SRC_COORD_W'(r_qx) : '0;
        n_result.src_y           = r_ctrl.cov ? SRC_COORD_W'(r_qy) : '0;
        n_result.src_byte_offset = r_ctrl.cov ? OFFS_W'(off3) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctrl <= i_ctrl;
            r_done <= r_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= PRW'(i_qy) * PRW'(i_w);
        r_qx     <= i_qx;
        r_qy     <= i_qy;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[src/quad_view_nearest_scaler_map.sv]
// top level of the 2x2 mosaic canvas to source address map
// path from start to o_done: the front stages, one divider cell per source coordinate bit,
//   then the offset stages
// throughput: one pixel transaction per cycle while busy is low; o_done cannot stall
// each frame size write raises busy while the serial divider refits that channel
// reset: synchronous active low, clears control state; all sizes zero, so all black
module quad_view_nearest_scaler_map_core #(
    parameter int CANVAS_WIDTH   = qvnsm_pkg::CANVAS_WIDTH_DEF,
    parameter int CANVAS_HEIGHT  = qvnsm_pkg::CANVAS_HEIGHT_DEF,
    parameter int MAX_SOURCE_DIM = qvnsm_pkg::MAX_SOURCE_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel request
    input  logic                          start,
    output logic                          busy,
    input  qvnsm_pkg::t_in                i_pixel,
    // mapping result
    output logic                          o_done,
    output qvnsm_pkg::t_out               o_result,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qvnsm_pkg::APB_AW-1:0]  paddr,
    input  logic [qvnsm_pkg::APB_DW-1:0]  pwdata,
    output logic [qvnsm_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import qvnsm_pkg::*;

    // cell size and datapath widths
    localparam int CELL_W   = CANVAS_WIDTH / 2;
    localparam int CELL_H   = CANVAS_HEIGHT / 2;
    localparam int CELL_MAX = (CELL_W > CELL_H) ? CELL_W : CELL_H;
    localparam int QW       = $clog2(CELL_MAX + 1);       // fitted size / offset bits
    localparam int SW       = $clog2(MAX_SOURCE_DIM);     // source coordinate bits
    localparam int RW       = DIM_W + QW + 1;             // divider remainder bits

    // frame size registers, even index width, odd index height
    logic [DIM_W-1:0] r_src_w [NUM_CH];
    logic [DIM_W-1:0] r_src_h [NUM_CH];
    logic             cfg_wr;
    logic [CH_W-1:0]  cfg_ch;
    logic             cfg_is_h;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_ch   = paddr[4:3];
    assign cfg_is_h = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_src_w[k] <= '0;
                r_src_h[k] <= '0;
            end
        end else if (cfg_wr) begin
            if (cfg_is_h) begin
                r_src_h[cfg_ch] <= pwdata[DIM_W-1:0];
            end else begin
                r_src_w[cfg_ch] <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata = cfg_is_h ? APB_DW'(r_src_h[cfg_ch]) : APB_DW'(r_src_w[cfg_ch]);

    // geometry of each channel: which axis limits, fitted size, centering offset
    logic            rd_sel_h;
    logic [QW-1:0]   rd_dw, rd_dh, rd_ox, rd_oy;
    logic [CH_W-1:0] rd_ch;
    logic            geom_busy;

    qvnsm_geom #(
        .CELL_W (CELL_W),
        .CELL_H (CELL_H),
        .QW     (QW)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (cfg_wr),
        .i_wr_ch    (cfg_ch),
        .i_src_w    (r_src_w),
        .i_src_h    (r_src_h),
        .i_rd_ch    (rd_ch),
        .o_rd_sel_h (rd_sel_h),
        .o_rd_dw    (rd_dw),
        .o_rd_dh    (rd_dh),
        .o_rd_ox    (rd_ox),
        .o_rd_oy    (rd_oy),
        .o_busy     (geom_busy)
    );

    // a pixel transaction is taken whenever the geometry is settled
    assign busy = geom_busy;

    // chain links: index 0 feeds the first divider cell
    t_ctrl            ln_ctrl  [SW+1];
    logic [DIM_W-1:0] ln_w     [SW+1];
    logic [RW-1:0]    ln_rem_x [SW+1];
    logic [RW-1:0]    ln_rem_y [SW+1];
    logic [SW-1:0]    ln_qx    [SW+1];
    logic [SW-1:0]    ln_qy    [SW+1];

    qvnsm_front #(
        .CELL_W         (CELL_W),
        .CELL_H         (CELL_H),
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .QW             (QW),
        .RW             (RW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_pixel    (i_pixel),
        .i_src_w    (r_src_w),
        .i_src_h    (r_src_h),
        .o_rd_ch    (rd_ch),
        .i_rd_sel_h (rd_sel_h),
        .i_rd_dw    (rd_dw),
        .i_rd_dh    (rd_dh),
        .i_rd_ox    (rd_ox),
        .i_rd_oy    (rd_oy),
        .o_ctrl     (ln_ctrl[0]),
        .o_w        (ln_w[0]),
        .o_rem_x    (ln_rem_x[0]),
        .o_rem_y    (ln_rem_y[0])
    );

    assign ln_qx[0] = '0;
    assign ln_qy[0] = '0;

    // restoring division by the cell size, most significant quotient bit first
    for (genvar g = 0; g < SW; g++) begin : g_cell
        qvnsm_cell #(
            .CELL_W (CELL_W),
            .CELL_H (CELL_H),
            .RW     (RW),
            .SW     (SW),
            .BIT    (SW - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ln_ctrl[g]),
            .i_w     (ln_w[g]),
            .i_rem_x (ln_rem_x[g]),
            .i_rem_y (ln_rem_y[g]),
            .i_qx    (ln_qx[g]),
            .i_qy    (ln_qy[g]),
            .o_ctrl  (ln_ctrl[g+1]),
            .o_w     (ln_w[g+1]),
            .o_rem_x (ln_rem_x[g+1]),
            .o_rem_y (ln_rem_y[g+1]),
            .o_qx    (ln_qx[g+1]),
            .o_qy    (ln_qy[g+1])
        );
    end

    // byte offset and registered result with its strobe
    qvnsm_addr #(
        .SW (SW)
    ) u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ln_ctrl[SW]),
        .i_w      (ln_w[SW]),
        .i_qx     (ln_qx[SW]),
        .i_qy     (ln_qy[SW]),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
